// File: sv/ggvc_pkg.sv
// Shared types and constants for the go-to-goal velocity controller.
// Holds the CORDIC vector beat, the register set and the arctangent table.
// No dependencies; every other file in sv/ imports this package.
`timescale 1ns / 1ps

package ggvc_pkg;

  // Datapath widths that follow from the fixed input field widths.
  localparam int XY_W       = 27;  // offset with guard bits plus CORDIC growth
  localparam int Z_W        = 33;  // accumulated angle, Q.30 radians
  localparam int HD_W       = 15;  // heading field
  localparam int POS_W      = 16;  // position field
  localparam int GAIN_W     = 16;
  localparam int ATOL_W     = 14;
  localparam int LIN_W      = 19;
  localparam int ANG_W      = 20;
  localparam int GUARD_BITS = 8;
  localparam int ANG_BITS   = 30;
  localparam int ATAN_W     = 30;
  localparam int ATAN_LEN   = 24;
  localparam int INV_W      = 31;

  // Angle constants in Q.30 radians.
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam longint PI_Q30     = 64'sd3373259426;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;

  // Reciprocal of the CORDIC gain, Q.30.
  localparam logic signed [INV_W-1:0] INV_GAIN_Q30 = 31'sd652032875;

  // Saturation limits of the velocity outputs.
  localparam longint LIN_MAX = 64'sd524287;
  localparam longint ANG_MAX = 64'sd524287;
  localparam longint ANG_MIN = -64'sd524288;

  // atan(2^-i) in Q.30 radians, truncated.
  localparam logic [ATAN_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LINEAR_GAIN  = 2'd0,
    CFG_ANGULAR_GAIN = 2'd1,
    CFG_DIST_TOL     = 2'd2,
    CFG_ANGLE_TOL    = 2'd3
  } ggvc_cfg_idx_t;

  // Register set as seen by the steering stages.
  typedef struct packed {
    logic [GAIN_W-1:0] linear_gain;
    logic [GAIN_W-1:0] angular_gain;
    logic [POS_W-1:0]  distance_tolerance;
    logic [ATOL_W-1:0] angle_tolerance;
  } ggvc_cfg_t;

  // One beat moving down the CORDIC chain.
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic signed [HD_W-1:0] hd;
  } ggvc_vec_t;

endpackage

// File: sv/ggvc_cell.sv
// One CORDIC vectoring cell: a single micro-rotation and its register.
// Depends on ggvc_pkg for the beat type and the arctangent table.
`timescale 1ns / 1ps

module ggvc_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ggvc_pkg::ggvc_vec_t in_vec,
  output logic               out_valid,
  output ggvc_pkg::ggvc_vec_t out_vec
);
  import ggvc_pkg::*;

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  angle;
  ggvc_vec_t              vec_next;

  // Rotate toward the x axis; the sign of y picks the direction.
  always_comb begin
    xs    = in_vec.x >>> STEP;
    ys    = in_vec.y >>> STEP;
    angle = {{(Z_W-ATAN_W){1'b0}}, ATAN_Q30[STEP]};
    vec_next.hd = in_vec.hd;
    if (!in_vec.y[XY_W-1]) begin
      vec_next.x = in_vec.x + ys;
      vec_next.y = in_vec.y - xs;
      vec_next.z = in_vec.z + angle;
    end else begin
      vec_next.x = in_vec.x - ys;
      vec_next.y = in_vec.y + xs;
      vec_next.z = in_vec.z - angle;
    end
  end

  // Valid bit is reset; the payload just follows.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_vec <= vec_next;
  end

endmodule

// File: sv/ggvc_steer.sv
// Steering back end: gain compensation, heading error, decision and scaling.
// Four registered stages after the CORDIC chain. Depends on ggvc_pkg.
`timescale 1ns / 1ps

module ggvc_steer #(
  parameter int FRACTION_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ggvc_pkg::ggvc_cfg_t           cfg,
  input  logic                          in_valid,
  input  ggvc_pkg::ggvc_vec_t           in_vec,
  output logic                          done,
  output logic [ggvc_pkg::LIN_W-1:0]    linear_velocity,
  output logic signed [ggvc_pkg::ANG_W-1:0] angular_velocity,
  output logic                          arrived,
  output logic                          turning
);
  import ggvc_pkg::*;

  localparam int HD_SHIFT  = ANG_BITS - FRACTION_BITS;
  localparam int ERR_W     = (((HD_W + HD_SHIFT) > Z_W) ? (HD_W + HD_SHIFT) : Z_W) + 2;
  localparam int PROD_W    = XY_W + INV_W;
  localparam int DIST_W    = XY_W - 1;
  localparam int LIN_P_W   = GAIN_W + DIST_W;
  localparam int ANG_P_W   = ERR_W + GAIN_W + 1;
  localparam int LIN_SHIFT = FRACTION_BITS + GUARD_BITS;

  localparam logic signed [ERR_W-1:0]   PI_E       = ERR_W'(PI_Q30);
  localparam logic signed [ERR_W-1:0]   TWO_PI_E   = ERR_W'(TWO_PI_Q30);
  localparam logic signed [PROD_W-1:0]  RND_DIST   = PROD_W'(64'sd1 <<< (ANG_BITS - 1));
  localparam logic signed [ANG_P_W-1:0] RND_ANG    = ANG_P_W'(64'sd1 <<< (ANG_BITS - 1));
  localparam logic [LIN_P_W:0]          RND_LIN    = (LIN_P_W+1)'(64'd1 << (LIN_SHIFT - 1));
  localparam logic [LIN_P_W:0]          LIN_MAX_E  = (LIN_P_W+1)'(LIN_MAX);
  localparam logic signed [ANG_P_W-1:0] ANG_MAX_E  = ANG_P_W'(ANG_MAX);
  localparam logic signed [ANG_P_W-1:0] ANG_MIN_E  = ANG_P_W'(ANG_MIN);

  // Stage A: gain compensation product and wrapped heading error.
  logic                       a_valid;
  logic signed [PROD_W-1:0]   a_prod;
  logic signed [ERR_W-1:0]    a_err;
  logic signed [PROD_W-1:0]   a_prod_next;
  logic signed [ERR_W-1:0]    z_e;
  logic signed [ERR_W-1:0]    hd_e;
  logic signed [ERR_W-1:0]    err0;
  logic signed [ERR_W-1:0]    err1;
  logic signed [ERR_W-1:0]    a_err_next;

  always_comb begin
    a_prod_next = in_vec.x * INV_GAIN_Q30;
    z_e         = ERR_W'(in_vec.z);
    hd_e        = ERR_W'(in_vec.hd) <<< HD_SHIFT;
    err0        = z_e - hd_e;
    // The error is wrapped only once each way.
    err1        = (err0 > PI_E) ? (err0 - TWO_PI_E) : err0;
    a_err_next  = (err1 < -PI_E) ? (err1 + TWO_PI_E) : err1;
  end

  // Stage B: distance, its tolerance check and the angle check.
  logic                     b_valid;
  logic [DIST_W-1:0]        b_dist;
  logic signed [ERR_W-1:0]  b_err;
  logic                     b_arrived;
  logic                     b_turning;
  logic signed [PROD_W-1:0] dist_full;
  logic [DIST_W-1:0]        b_dist_next;
  logic [ERR_W-1:0]         abs_err;
  logic [ERR_W-1:0]         tol_e;
  logic                     b_arrived_next;
  logic                     b_turning_next;

  always_comb begin
    dist_full      = (a_prod + RND_DIST) >>> ANG_BITS;
    b_dist_next    = dist_full[PROD_W-1] ? '0 : dist_full[DIST_W-1:0];
    b_arrived_next = b_dist_next <=
                     DIST_W'({cfg.distance_tolerance, {GUARD_BITS{1'b0}}});
    abs_err        = a_err[ERR_W-1] ? ERR_W'(-a_err) : ERR_W'(a_err);
    tol_e          = ERR_W'(cfg.angle_tolerance) << HD_SHIFT;
    b_turning_next = !b_arrived_next && (abs_err > tol_e);
  end

  // Stage C: gain products, one for each branch.
  logic                       c_valid;
  logic [LIN_P_W-1:0]         c_plin;
  logic signed [ANG_P_W-1:0]  c_pang;
  logic                       c_arrived;
  logic                       c_turning;
  logic signed [GAIN_W:0]     ang_gain_s;

  assign ang_gain_s = {1'b0, cfg.angular_gain};

  // Stage D: round, saturate and select the outputs.
  logic [LIN_P_W:0]           lin_r;
  logic [LIN_W-1:0]           lin_sat;
  logic signed [ANG_P_W-1:0]  ang_r;
  logic signed [ANG_W-1:0]    ang_sat;
  logic [LIN_W-1:0]           linear_velocity_next;
  logic signed [ANG_W-1:0]    angular_velocity_next;

  always_comb begin
    lin_r = ({1'b0, c_plin} + RND_LIN) >> LIN_SHIFT;
    lin_sat = (lin_r > LIN_MAX_E) ? LIN_W'(LIN_MAX) : lin_r[LIN_W-1:0];
    ang_r = (c_pang + RND_ANG) >>> ANG_BITS;
    if (ang_r > ANG_MAX_E) begin
      ang_sat = ANG_W'(ANG_MAX);
    end else if (ang_r < ANG_MIN_E) begin
      ang_sat = ANG_W'(ANG_MIN);
    end else begin
      ang_sat = ang_r[ANG_W-1:0];
    end
    linear_velocity_next  = (c_arrived || c_turning) ? '0 : lin_sat;
    angular_velocity_next = c_turning ? ang_sat : '0;
  end

  // Valid bits of all stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      done    <= c_valid;
    end
  end

  // Payload registers of all stages.
  always_ff @(posedge clk) begin
    a_prod           <= a_prod_next;
    a_err            <= a_err_next;
    b_dist           <= b_dist_next;
    b_err            <= a_err;
    b_arrived        <= b_arrived_next;
    b_turning        <= b_turning_next;
    c_plin           <= cfg.linear_gain * b_dist;
    c_pang           <= ang_gain_s * b_err;
    c_arrived        <= b_arrived;
    c_turning        <= b_turning;
    linear_velocity  <= linear_velocity_next;
    angular_velocity <= angular_velocity_next;
    arrived          <= c_arrived;
    turning          <= c_turning;
  end

endmodule

// File: sv/go_to_goal_velocity_controller.sv
// Go-to-goal velocity controller: one pose beat in, one command beat out.
// done rises once a beat has passed the input register, the CORDIC cells and the steering stages.
// Throughput: one beat per cycle; every stage is a register, so busy stays low.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears all stage valid bits and loads the register defaults.
// Depends on ggvc_pkg, ggvc_cell and ggvc_steer.
`timescale 1ns / 1ps

module go_to_goal_velocity_controller #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [ggvc_pkg::GAIN_W-1:0]       cfg_data,
  input  logic [ggvc_pkg::POS_W-1:0]        target_x,
  input  logic [ggvc_pkg::POS_W-1:0]        target_y,
  input  logic [ggvc_pkg::POS_W-1:0]        pose_x,
  input  logic [ggvc_pkg::POS_W-1:0]        pose_y,
  input  logic signed [ggvc_pkg::HD_W-1:0]  pose_heading,
  output logic                              done,
  output logic [ggvc_pkg::LIN_W-1:0]        linear_velocity,
  output logic signed [ggvc_pkg::ANG_W-1:0] angular_velocity,
  output logic                              arrived,
  output logic                              turning
);
  import ggvc_pkg::*;

  localparam int DIFF_W = POS_W + 1;

  ggvc_cfg_t cfg;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linear_gain        <= GAIN_W'(2048);
      cfg.angular_gain       <= GAIN_W'(2048);
      cfg.distance_tolerance <= POS_W'(410);
      cfg.angle_tolerance    <= ATOL_W'(410);
    end else if (cfg_write) begin
      unique case (ggvc_cfg_idx_t'(cfg_index))
        CFG_LINEAR_GAIN:  cfg.linear_gain        <= cfg_data;
        CFG_ANGULAR_GAIN: cfg.angular_gain       <= cfg_data;
        CFG_DIST_TOL:     cfg.distance_tolerance <= cfg_data;
        CFG_ANGLE_TOL:    cfg.angle_tolerance    <= cfg_data[ATOL_W-1:0];
        default:          cfg.linear_gain        <= cfg.linear_gain;
      endcase
    end
  end

  // Every stage takes a new beat each cycle.
  assign busy = 1'b0;

  // Offset with guard bits, pre-rotated into the right half-plane.
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [XY_W-1:0]   dx_g;
  logic signed [XY_W-1:0]   dy_g;
  ggvc_vec_t                pre_vec_next;
  ggvc_vec_t                pre_vec;
  logic                     pre_valid;

  always_comb begin
    dx   = $signed({1'b0, target_x}) - $signed({1'b0, pose_x});
    dy   = $signed({1'b0, target_y}) - $signed({1'b0, pose_y});
    dx_g = {{(XY_W-DIFF_W-GUARD_BITS){dx[DIFF_W-1]}}, dx, {GUARD_BITS{1'b0}}};
    dy_g = {{(XY_W-DIFF_W-GUARD_BITS){dy[DIFF_W-1]}}, dy, {GUARD_BITS{1'b0}}};
    pre_vec_next.hd = pose_heading;
    if (!dx_g[XY_W-1]) begin
      pre_vec_next.x = dx_g;
      pre_vec_next.y = dy_g;
      pre_vec_next.z = '0;
    end else if (!dy_g[XY_W-1]) begin
      pre_vec_next.x = dy_g;
      pre_vec_next.y = -dx_g;
      pre_vec_next.z = HALF_PI_Q30;
    end else begin
      pre_vec_next.x = -dy_g;
      pre_vec_next.y = dx_g;
      pre_vec_next.z = -HALF_PI_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_valid <= 1'b0;
    end else begin
      pre_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    pre_vec <= pre_vec_next;
  end

  // CORDIC chain: one cell per micro-rotation.
  logic      chain_valid [CORDIC_STEPS+1];
  ggvc_vec_t chain_vec   [CORDIC_STEPS+1];

  assign chain_valid[0] = pre_valid;
  assign chain_vec[0]   = pre_vec;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    ggvc_cell #(
      .STEP(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (chain_valid[i]),
      .in_vec   (chain_vec[i]),
      .out_valid(chain_valid[i+1]),
      .out_vec  (chain_vec[i+1])
    );
  end

  // Distance, heading error and the steering decision.
  ggvc_steer #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_steer (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (chain_valid[CORDIC_STEPS]),
    .in_vec          (chain_vec[CORDIC_STEPS]),
    .done            (done),
    .linear_velocity (linear_velocity),
    .angular_velocity(angular_velocity),
    .arrived         (arrived),
    .turning         (turning)
  );

endmodule

// File: sv/ggvc_checker.sv
// Port-level checker for the go-to-goal velocity controller, with its bind.
// Sees only the top-level ports; depends on ggvc_pkg for field widths.
`timescale 1ns / 1ps

module ggvc_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic [ggvc_pkg::LIN_W-1:0]        linear_velocity,
  input logic signed [ggvc_pkg::ANG_W-1:0] angular_velocity,
  input logic                              arrived,
  input logic                              turning
);
  import ggvc_pkg::*;

  localparam int LATENCY = CORDIC_STEPS + 5;

  // Every result beat comes from a beat accepted a fixed time earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result beat without a matching accepted beat");

  // Arrival and turning in place exclude each other.
  a_modes: assert property (@(posedge clk) disable iff (rst)
    done |-> !(arrived && turning))
    else $error("arrived and turning both set");

  // On arrival both commands are zero.
  a_stop: assert property (@(posedge clk) disable iff (rst)
    done && arrived |-> (linear_velocity == '0) && (angular_velocity == '0))
    else $error("nonzero command after arrival");

  // Turning in place gives no forward speed; driving gives no turn rate.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> (turning ? (linear_velocity == '0) : (angular_velocity == '0)))
    else $error("forward and turn commands both active");

endmodule

bind go_to_goal_velocity_controller ggvc_checker #(
  .CORDIC_STEPS(CORDIC_STEPS)
) u_ggvc_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .linear_velocity (linear_velocity),
  .angular_velocity(angular_velocity),
  .arrived         (arrived),
  .turning         (turning)
);
